@@ rtl/nixie_scan_and_cathode_cycle_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the nixie scan and cathode cycle block
// Clocked implication checks, disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef NIXIE_SCAN_AND_CATHODE_CYCLE_ASSERT_SVH
`define NIXIE_SCAN_AND_CATHODE_CYCLE_ASSERT_SVH

// same-cycle implication
`define NSCC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("nscc assertion failed");

// next-cycle implication
`define NSCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("nscc assertion failed");

`endif

@@ rtl/nscc_pkg.sv @@
// ----------------------------------------------------------------------------
// nscc_pkg
// Widths, codes, reset values and helpers for the nixie sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package nscc_pkg;

    localparam int NUM_TUBES       = 6;
    localparam int DIGIT_W         = 4;
    localparam int TIME_W          = 31;
    localparam int CFG_W           = 16;
    localparam int POS_W           = 3;
    localparam int APB_ADDR_W      = 4;
    localparam int APB_DATA_W      = 32;
    localparam int SCAN_DIVIDE_DEF = 10;

    typedef logic [DIGIT_W-1:0] t_digit;
    typedef logic [CFG_W-1:0]   t_cfg;
    typedef logic [TIME_W-1:0]  t_time;
    typedef logic [1:0]         t_reg_idx;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SET  = 1'b1;

    localparam t_reg_idx REG_INTERVAL = 2'd0;
    localparam t_reg_idx REG_DURATION = 2'd1;
    localparam t_reg_idx REG_STALE    = 2'd2;

    localparam t_cfg INTERVAL_RST = 16'd300;
    localparam t_cfg DURATION_RST = 16'd10;
    localparam t_cfg STALE_RST    = 16'd1200;

    localparam t_digit BLANK_CODE = 4'd15;
    localparam t_digit SCAN_LIT   = 4'd1;
    localparam t_digit DEC_LAST   = 4'd9;

    localparam logic [POS_W-1:0] POS_FIRST = 3'd1;
    localparam logic [POS_W-1:0] POS_LAST  = 3'd6;

    function automatic t_digit cyc_digit(input t_digit idx, input logic [POS_W-1:0] k);
        logic [DIGIT_W:0] s;
        s = {1'b0, idx} + {2'b0, k};
        if (s >= 5'd10) begin
            s = s - 5'd10;
        end
        return s[DIGIT_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/nscc_in_if.sv @@
// ----------------------------------------------------------------------------
// nscc_in_if
// Input channel: tick or set-digits beat with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface nscc_in_if import nscc_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   operation;
    t_time  now_seconds;
    t_digit digit_one;
    t_digit digit_two;
    t_digit digit_three;
    t_digit digit_four;
    t_digit digit_five;
    t_digit digit_six;

    modport source (
        output valid, operation, now_seconds,
               digit_one, digit_two, digit_three, digit_four, digit_five, digit_six,
        input  ready
    );

    modport sink (
        input  valid, operation, now_seconds,
               digit_one, digit_two, digit_three, digit_four, digit_five, digit_six,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/nscc_out_if.sv @@
// ----------------------------------------------------------------------------
// nscc_out_if
// Output channel: six tube values per beat with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface nscc_out_if import nscc_pkg::*; ();
    logic   valid;
    logic   ready;
    t_digit tube_one;
    t_digit tube_two;
    t_digit tube_three;
    t_digit tube_four;
    t_digit tube_five;
    t_digit tube_six;

    modport source (
        output valid, tube_one, tube_two, tube_three, tube_four, tube_five, tube_six,
        input  ready
    );

    modport sink (
        input  valid, tube_one, tube_two, tube_three, tube_four, tube_five, tube_six,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/nixie_scan_and_cathode_cycle.sv @@
// A tick beat is held in the input register and its result in the result
// register. Throughput: one beat per cycle unless the output stalls; the input
// register lets one more beat enter while a finished result waits to be taken.
// Reset (synchronous, active low) clears the digits, the valid flags and the
// scan and cycle state, turns the scan direction upward, and loads the
// registers with 300, 10 and 1200 seconds.
// ----------------------------------------------------------------------------
// nixie_scan_and_cathode_cycle
// Six-tube sequencer: start-up scan, stored digits and cathode cycling runs.
// ----------------------------------------------------------------------------
`default_nettype none
`include "nixie_scan_and_cathode_cycle_assert.svh"

module nixie_scan_and_cathode_cycle
    import nscc_pkg::*;
#(
    parameter int SCAN_DIVIDE = SCAN_DIVIDE_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    nscc_in_if.sink                    i_in,
    nscc_out_if.source                 o_out
);

    localparam int CntW = (SCAN_DIVIDE > 1) ? $clog2(SCAN_DIVIDE) : 1;
    localparam logic [CntW-1:0] CntLast = CntW'(SCAN_DIVIDE - 1);

    t_cfg r_interval, r_duration, r_stale;

    logic                         r_in_valid;
    logic                         r_in_op;
    t_time                        r_in_now;
    t_digit [NUM_TUBES-1:0]       r_in_digits;

    t_digit [NUM_TUBES-1:0]       r_shown,      n_shown;
    logic                         r_digits_valid, n_digits_valid;
    logic [CntW-1:0]              r_scan_cnt,   n_scan_cnt;
    logic [POS_W-1:0]             r_lit_pos,    n_lit_pos;
    logic                         r_scan_rising, n_scan_rising;
    logic                         r_cyc_active, n_cyc_active;
    t_time                        r_cyc_start,  n_cyc_start;
    t_digit                       r_cyc_index,  n_cyc_index;

    logic                         r_out_valid;
    t_digit [NUM_TUBES-1:0]       r_tube,       n_tube;

    logic                         cfg_wr;
    t_reg_idx                     cfg_idx;
    logic                         s1_go;
    logic                         in_acc;
    logic signed [TIME_W:0]       age;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        unique case (cfg_idx)
            REG_INTERVAL: prdata = {{(APB_DATA_W-CFG_W){1'b0}}, r_interval};
            REG_DURATION: prdata = {{(APB_DATA_W-CFG_W){1'b0}}, r_duration};
            REG_STALE:    prdata = {{(APB_DATA_W-CFG_W){1'b0}}, r_stale};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= INTERVAL_RST;
            r_duration <= DURATION_RST;
            r_stale    <= STALE_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_INTERVAL: r_interval <= pwdata[CFG_W-1:0];
                REG_DURATION: r_duration <= pwdata[CFG_W-1:0];
                REG_STALE:    r_stale    <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake
    assign s1_go      = r_in_valid && (r_in_op == OP_SET || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || s1_go;
    assign in_acc     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (s1_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_op        <= i_in.operation;
            r_in_now       <= i_in.now_seconds;
            r_in_digits[0] <= i_in.digit_one;
            r_in_digits[1] <= i_in.digit_two;
            r_in_digits[2] <= i_in.digit_three;
            r_in_digits[3] <= i_in.digit_four;
            r_in_digits[4] <= i_in.digit_five;
            r_in_digits[5] <= i_in.digit_six;
        end
    end

    assign age = $signed({1'b0, r_in_now}) - $signed({1'b0, r_cyc_start});

    // per-beat work
    always_comb begin
        n_shown        = r_shown;
        n_digits_valid = r_digits_valid;
        n_scan_cnt     = r_scan_cnt;
        n_lit_pos      = r_lit_pos;
        n_scan_rising  = r_scan_rising;
        n_cyc_active   = r_cyc_active;
        n_cyc_start    = r_cyc_start;
        n_cyc_index    = r_cyc_index;
        n_tube         = r_shown;

        if (r_in_op == OP_SET) begin
            n_shown        = r_in_digits;
            n_digits_valid = 1'b1;
        end else if (!r_digits_valid) begin
            if (r_scan_cnt == '0) begin
                if (r_scan_rising) begin
                    if (r_lit_pos >= POS_LAST - 3'd1) begin
                        n_lit_pos     = POS_LAST;
                        n_scan_rising = 1'b0;
                    end else if (r_lit_pos == '0) begin
                        n_lit_pos     = POS_FIRST;
                    end else begin
                        n_lit_pos     = r_lit_pos + 3'd1;
                    end
                end else begin
                    if (r_lit_pos <= POS_FIRST + 3'd1) begin
                        n_lit_pos     = POS_FIRST;
                        n_scan_rising = 1'b1;
                    end else if (r_lit_pos > POS_LAST) begin
                        n_lit_pos     = POS_LAST;
                    end else begin
                        n_lit_pos     = r_lit_pos - 3'd1;
                    end
                end
                for (int k = 0; k < NUM_TUBES; k++) begin
                    n_shown[k] = (n_lit_pos == POS_W'(k + 1)) ? SCAN_LIT : BLANK_CODE;
                end
            end
            n_scan_cnt = (r_scan_cnt >= CntLast) ? '0 : r_scan_cnt + CntW'(1);
            n_tube     = n_shown;
        end else begin
            if (r_cyc_active && age < $signed({{(TIME_W+1-CFG_W){1'b0}}, r_duration})) begin
                for (int k = 0; k < NUM_TUBES; k++) begin
                    n_tube[k] = cyc_digit(r_cyc_index, POS_W'(k));
                end
                n_cyc_index = (r_cyc_index >= DEC_LAST) ? '0 : r_cyc_index + 4'd1;
            end else begin
                n_tube       = r_shown;
                n_cyc_active = 1'b0;
            end
            if (age > $signed({{(TIME_W+1-CFG_W){1'b0}}, r_stale})) begin
                n_cyc_start = r_in_now;
            end else if (age > $signed({{(TIME_W+1-CFG_W){1'b0}}, r_interval})) begin
                n_cyc_start  = r_in_now;
                n_cyc_active = 1'b1;
                n_cyc_index  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shown        <= '0;
            r_digits_valid <= 1'b0;
            r_scan_cnt     <= '0;
            r_lit_pos      <= '0;
            r_scan_rising  <= 1'b1;
            r_cyc_active   <= 1'b0;
            r_cyc_start    <= '0;
            r_cyc_index    <= '0;
        end else if (s1_go) begin
            r_shown        <= n_shown;
            r_digits_valid <= n_digits_valid;
            r_scan_cnt     <= n_scan_cnt;
            r_lit_pos      <= n_lit_pos;
            r_scan_rising  <= n_scan_rising;
            r_cyc_active   <= n_cyc_active;
            r_cyc_start    <= n_cyc_start;
            r_cyc_index    <= n_cyc_index;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_in_op == OP_TICK) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_in_op == OP_TICK) begin
            r_tube <= n_tube;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.tube_one   = r_tube[0];
    assign o_out.tube_two   = r_tube[1];
    assign o_out.tube_three = r_tube[2];
    assign o_out.tube_four  = r_tube[3];
    assign o_out.tube_five  = r_tube[4];
    assign o_out.tube_six   = r_tube[5];

    `NSCC_ASSERT_NEXT(a_set_marks_valid, i_clk, i_rst_n,
        s1_go && r_in_op == OP_SET, r_digits_valid)
    `NSCC_ASSERT_SAME(a_valid_sticks, i_clk, i_rst_n, 1'b1, !$fell(r_digits_valid))
    `NSCC_ASSERT_SAME(a_index_decimal, i_clk, i_rst_n, 1'b1, r_cyc_index <= DEC_LAST)
    `NSCC_ASSERT_SAME(a_pos_range, i_clk, i_rst_n, 1'b1, r_lit_pos <= POS_LAST)
    `NSCC_ASSERT_NEXT(a_set_no_result, i_clk, i_rst_n,
        s1_go && r_in_op == OP_SET && !r_out_valid, !r_out_valid)

endmodule

`default_nettype wire
